// ===== rtl/utt_pkg.sv =====
// Package for the unit-step-toward-target block: configuration constants,
// register indexes and default parameter values. No dependencies.
`default_nettype none
package utt_pkg;
  localparam int DEF_COORD_WIDTH = 24;
  localparam int DEF_FRAC_BITS   = 8;
  localparam int MIN_DIST_WIDTH  = 23;
  localparam logic [MIN_DIST_WIDTH-1:0] MIN_DIST_RESET = 23'd128;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_ADDR_WIDTH  = 3;
  // Register index is the byte address divided by four.
  localparam logic REG_MIN_DISTANCE = 1'b0;
endpackage
`default_nettype wire

// ===== rtl/utt_in_if.sv =====
// Input channel interface: one entity word (head, body and destination points).
// Depends on utt_pkg for the default coordinate width.
`default_nettype none
interface utt_in_if import utt_pkg::*; #(parameter int CW = DEF_COORD_WIDTH);
  logic          valid;
  logic          ready;
  logic [CW-1:0] head_x;
  logic [CW-1:0] head_y;
  logic [CW-1:0] body_x;
  logic [CW-1:0] body_y;
  logic [CW-1:0] dest_x;
  logic [CW-1:0] dest_y;
  modport source (output valid, head_x, head_y, body_x, body_y, dest_x, dest_y,
                  input ready);
  modport sink (input valid, head_x, head_y, body_x, body_y, dest_x, dest_y,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/utt_out_if.sv =====
// Result channel interface: updated head and body points and the moved flag.
// Depends on utt_pkg for the default coordinate width.
`default_nettype none
interface utt_out_if import utt_pkg::*; #(parameter int CW = DEF_COORD_WIDTH);
  logic          valid;
  logic          ready;
  logic [CW-1:0] new_head_x;
  logic [CW-1:0] new_head_y;
  logic [CW-1:0] new_body_x;
  logic [CW-1:0] new_body_y;
  logic          moved;
  modport source (output valid, new_head_x, new_head_y, new_body_x, new_body_y,
                  moved, input ready);
  modport sink (input valid, new_head_x, new_head_y, new_body_x, new_body_y,
                moved, output ready);
endinterface
`default_nettype wire

// ===== rtl/utt_lane.sv =====
// One point's lane: difference vector, squares, pipelined integer square root
// and two pipelined restoring dividers for the unit direction. Uses utt_pkg.
`default_nettype none
module utt_lane import utt_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH,
  parameter int F  = DEF_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [CW-1:0] px,
  input  wire logic [CW-1:0] py,
  input  wire logic [CW-1:0] tx,
  input  wire logic [CW-1:0] ty,
  output logic [CW-1:0]      px_o,
  output logic [CW-1:0]      py_o,
  output logic [CW+1:0]      len_o,
  output logic [F:0]         qx_o,
  output logic [F:0]         qy_o,
  output logic               nx_o,
  output logic               ny_o
);
  localparam int M   = CW + 1;
  localparam int R   = CW + 2;
  localparam int RW  = R + 2;
  localparam int DW  = R + 1;

  logic [M-1:0]   dx, dy;
  logic [M-1:0]   s0_ax_r, s0_ay_r;
  logic           s0_nx_r, s0_ny_r;
  logic [CW-1:0]  s0_px_r, s0_py_r;
  logic [2*M-1:0] s1_sx_r, s1_sy_r;
  logic [M-1:0]   s1_ax_r, s1_ay_r;
  logic           s1_nx_r, s1_ny_r;
  logic [CW-1:0]  s1_px_r, s1_py_r;

  // Square root pipeline: index 0 is the input, index R the finished root.
  logic [2*R-1:0] sm_r [0:R];
  logic [RW-1:0]  rm_r [0:R];
  logic [R-1:0]   rt_r [0:R];
  logic [M-1:0]   qax_r [0:R];
  logic [M-1:0]   qay_r [0:R];
  logic           qnx_r [0:R];
  logic           qny_r [0:R];
  logic [CW-1:0]  qpx_r [0:R];
  logic [CW-1:0]  qpy_r [0:R];

  // Divider pipeline: one quotient bit per stage, F+1 stages.
  logic [DW-1:0]  drx_r [0:F+1];
  logic [DW-1:0]  dry_r [0:F+1];
  logic [F:0]     dqx_r [0:F+1];
  logic [F:0]     dqy_r [0:F+1];
  logic [R-1:0]   dl_r  [0:F+1];
  logic           dnx_r [0:F+1];
  logic           dny_r [0:F+1];
  logic [CW-1:0]  dpx_r [0:F+1];
  logic [CW-1:0]  dpy_r [0:F+1];

  assign dx = {tx[CW-1], tx} - {px[CW-1], px};
  assign dy = {ty[CW-1], ty} - {py[CW-1], py};

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax_r <= dx[M-1] ? (~dx + 1'b1) : dx;
      s0_ay_r <= dy[M-1] ? (~dy + 1'b1) : dy;
      s0_nx_r <= dx[M-1];
      s0_ny_r <= dy[M-1];
      s0_px_r <= px;
      s0_py_r <= py;
      s1_sx_r <= s0_ax_r * s0_ax_r;
      s1_sy_r <= s0_ay_r * s0_ay_r;
      s1_ax_r <= s0_ax_r;
      s1_ay_r <= s0_ay_r;
      s1_nx_r <= s0_nx_r;
      s1_ny_r <= s0_ny_r;
      s1_px_r <= s0_px_r;
      s1_py_r <= s0_py_r;
      sm_r[0]  <= (2*R)'(s1_sx_r) + (2*R)'(s1_sy_r);
      rm_r[0]  <= '0;
      rt_r[0]  <= '0;
      qax_r[0] <= s1_ax_r;
      qay_r[0] <= s1_ay_r;
      qnx_r[0] <= s1_nx_r;
      qny_r[0] <= s1_ny_r;
      qpx_r[0] <= s1_px_r;
      qpy_r[0] <= s1_py_r;
    end
  end

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    localparam int P = R - 1 - i;
    logic [RW-1:0] rem_sh, trial;
    assign rem_sh = {rm_r[i][RW-3:0], sm_r[i][2*P+1:2*P]};
    assign trial  = {rt_r[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rm_r[i+1] <= rem_sh - trial;
          rt_r[i+1] <= {rt_r[i][R-2:0], 1'b1};
        end else begin
          rm_r[i+1] <= rem_sh;
          rt_r[i+1] <= {rt_r[i][R-2:0], 1'b0};
        end
        sm_r[i+1]  <= sm_r[i];
        qax_r[i+1] <= qax_r[i];
        qay_r[i+1] <= qay_r[i];
        qnx_r[i+1] <= qnx_r[i];
        qny_r[i+1] <= qny_r[i];
        qpx_r[i+1] <= qpx_r[i];
        qpy_r[i+1] <= qpy_r[i];
      end
    end
  end

  // The high part of |d| << F is below the length, so the remainder starts there.
  assign drx_r[0] = DW'(qax_r[R] >> 1);
  assign dry_r[0] = DW'(qay_r[R] >> 1);
  assign dqx_r[0] = '0;
  assign dqy_r[0] = '0;
  assign dl_r[0]  = rt_r[R];
  assign dnx_r[0] = qnx_r[R];
  assign dny_r[0] = qny_r[R];
  assign dpx_r[0] = qpx_r[R];
  assign dpy_r[0] = qpy_r[R];

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic          bx, by;
    logic [DW-1:0] shx, shy, dvs;
    // Only the top quotient step brings in a dividend bit; the rest are zeros.
    assign bx  = (j == 0) ? qax_r[R][0] : 1'b0;
    assign by  = (j == 0) ? qay_r[R][0] : 1'b0;
    assign shx = {drx_r[j][DW-2:0], bx};
    assign shy = {dry_r[j][DW-2:0], by};
    assign dvs = {1'b0, dl_r[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (shx >= dvs) begin
          drx_r[j+1] <= shx - dvs;
          dqx_r[j+1] <= {dqx_r[j][F-1:0], 1'b1};
        end else begin
          drx_r[j+1] <= shx;
          dqx_r[j+1] <= {dqx_r[j][F-1:0], 1'b0};
        end
        if (shy >= dvs) begin
          dry_r[j+1] <= shy - dvs;
          dqy_r[j+1] <= {dqy_r[j][F-1:0], 1'b1};
        end else begin
          dry_r[j+1] <= shy;
          dqy_r[j+1] <= {dqy_r[j][F-1:0], 1'b0};
        end
        dl_r[j+1]  <= dl_r[j];
        dnx_r[j+1] <= dnx_r[j];
        dny_r[j+1] <= dny_r[j];
        dpx_r[j+1] <= dpx_r[j];
        dpy_r[j+1] <= dpy_r[j];
      end
    end
  end

  assign px_o  = dpx_r[F+1];
  assign py_o  = dpy_r[F+1];
  assign len_o = dl_r[F+1];
  assign qx_o  = dqx_r[F+1];
  assign qy_o  = dqy_r[F+1];
  assign nx_o  = dnx_r[F+1];
  assign ny_o  = dny_r[F+1];
endmodule
`default_nettype wire

// ===== rtl/utt_merge.sv =====
// Merging stage: compares both lane lengths with the threshold, applies the
// signed steps with saturation and registers the result word. Uses utt_pkg.
`default_nettype none
module utt_merge import utt_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH,
  parameter int F  = DEF_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [MIN_DIST_WIDTH-1:0] min_dist,
  input  wire logic [CW-1:0]             hpx,
  input  wire logic [CW-1:0]             hpy,
  input  wire logic [CW+1:0]             hlen,
  input  wire logic [F:0]                hqx,
  input  wire logic [F:0]                hqy,
  input  wire logic                      hnx,
  input  wire logic                      hny,
  input  wire logic [CW-1:0]             bpx,
  input  wire logic [CW-1:0]             bpy,
  input  wire logic [CW+1:0]             blen,
  input  wire logic [F:0]                bqx,
  input  wire logic [F:0]                bqy,
  input  wire logic                      bnx,
  input  wire logic                      bny,
  output logic [CW-1:0]                  nhx_r,
  output logic [CW-1:0]                  nhy_r,
  output logic [CW-1:0]                  nbx_r,
  output logic [CW-1:0]                  nby_r,
  output logic                           moved_r
);
  localparam int R  = CW + 2;
  localparam int CM = (R > MIN_DIST_WIDTH) ? R : MIN_DIST_WIDTH;

  logic go;

  function automatic logic [CW-1:0] step_sat(input logic [CW-1:0] p,
                                             input logic [F:0] q,
                                             input logic neg);
    logic [CW+1:0] st, sm;
    st = (CW+2)'(q);
    if (neg) st = ~st + 1'b1;
    sm = {{2{p[CW-1]}}, p} + st;
    // The top three bits must agree for the sum to fit the coordinate range.
    if (sm[CW+1:CW-1] == 3'b000 || sm[CW+1:CW-1] == 3'b111) begin
      return sm[CW-1:0];
    end else if (sm[CW+1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign go = (CM'(hlen) > CM'(min_dist)) && (CM'(blen) > CM'(min_dist));

  always_ff @(posedge clk) begin
    if (en) begin
      moved_r <= go;
      nhx_r   <= go ? step_sat(hpx, hqx, hnx) : hpx;
      nhy_r   <= go ? step_sat(hpy, hqy, hny) : hpy;
      nbx_r   <= go ? step_sat(bpx, bqx, bnx) : bpx;
      nby_r   <= go ? step_sat(bpy, bqy, bny) : bpy;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/unit_step_toward_target.sv =====
// Top level: two point lanes (head, body), the merging stage, the valid
// pipeline and the APB register. Uses utt_pkg, utt_in_if, utt_out_if.
//
//   channel   | direction | word
//   in_item   | sink      | head_x, head_y, body_x, body_y, dest_x, dest_y
//   out_item  | source    | new_head_x, new_head_y, new_body_x, new_body_y, moved
//   cfg_*     | APB slave | min_distance at byte address 0
//
// One word is accepted per cycle while the pipeline is not held. Stages in order:
// three for difference, squares and sum, COORD_WIDTH+2 square root steps,
// FRAC_BITS+1 divider steps and the output register.
// The whole pipeline advances together; it holds while a result waits untaken.
// rst_n clears the valid pipeline and loads min_distance with 0.5.
`default_nettype none
module unit_step_toward_target import utt_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  utt_in_if.sink                         in_item,
  utt_out_if.source                      out_item,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_pwdata,
  output logic [CFG_DATA_WIDTH-1:0]      cfg_prdata,
  output logic                           cfg_pready
);
  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int LAT = 3 + (CW + 2) + (F + 1);

  logic                      adv;
  logic [LAT-1:0]            vld_r;
  logic                      out_valid_r;
  logic [MIN_DIST_WIDTH-1:0] min_dist_r;
  logic                      cfg_wr;

  logic [CW-1:0] hpx, hpy, bpx, bpy;
  logic [CW+1:0] hlen, blen;
  logic [F:0]    hqx, hqy, bqx, bqy;
  logic          hnx, hny, bnx, bny;

  assign adv           = !out_valid_r || out_item.ready;
  assign in_item.ready = adv;
  assign out_item.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_item.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_DISTANCE)
                    ? CFG_DATA_WIDTH'(min_dist_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_MIN_DISTANCE) begin
      min_dist_r <= cfg_pwdata[MIN_DIST_WIDTH-1:0];
    end
  end

  utt_lane #(.CW(CW), .F(F)) u_head (
    .clk(clk), .en(adv),
    .px(in_item.head_x), .py(in_item.head_y),
    .tx(in_item.dest_x), .ty(in_item.dest_y),
    .px_o(hpx), .py_o(hpy), .len_o(hlen), .qx_o(hqx), .qy_o(hqy),
    .nx_o(hnx), .ny_o(hny)
  );

  utt_lane #(.CW(CW), .F(F)) u_body (
    .clk(clk), .en(adv),
    .px(in_item.body_x), .py(in_item.body_y),
    .tx(in_item.dest_x), .ty(in_item.dest_y),
    .px_o(bpx), .py_o(bpy), .len_o(blen), .qx_o(bqx), .qy_o(bqy),
    .nx_o(bnx), .ny_o(bny)
  );

  utt_merge #(.CW(CW), .F(F)) u_merge (
    .clk(clk), .en(adv), .min_dist(min_dist_r),
    .hpx(hpx), .hpy(hpy), .hlen(hlen), .hqx(hqx), .hqy(hqy), .hnx(hnx), .hny(hny),
    .bpx(bpx), .bpy(bpy), .blen(blen), .bqx(bqx), .bqy(bqy), .bnx(bnx), .bny(bny),
    .nhx_r(out_item.new_head_x), .nhy_r(out_item.new_head_y),
    .nbx_r(out_item.new_body_x), .nby_r(out_item.new_body_y),
    .moved_r(out_item.moved)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_item.valid && vld_r == '0)
    else $error("pipeline not empty after reset");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_paddr[2] == REG_MIN_DISTANCE
      |=> min_dist_r == $past(cfg_pwdata[MIN_DIST_WIDTH-1:0]))
    else $error("min_distance write lost");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid pipeline moved during a stall");
endmodule
`default_nettype wire

// ===== test/utt_checker.sv =====
// Checker for the unit-step-toward-target block: watches both channels, predicts
// each result word from the accepted entity word and compares. Uses utt_pkg.
module utt_checker import utt_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic [23:0]               in_hx,
  input  wire logic [23:0]               in_hy,
  input  wire logic [23:0]               in_bx,
  input  wire logic [23:0]               in_by,
  input  wire logic [23:0]               in_tx,
  input  wire logic [23:0]               in_ty,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [23:0]               out_hx,
  input  wire logic [23:0]               out_hy,
  input  wire logic [23:0]               out_bx,
  input  wire logic [23:0]               out_by,
  input  wire logic                      out_moved,
  input  wire logic [MIN_DIST_WIDTH-1:0] min_dist,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] hx, hy, bx, by;
    logic        moved;
  } step_word_t;

  step_word_t expected_steps[$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // One-unit step along a difference vector of the given length; sums fit in 64 bits.
  function automatic longint step_part(longint d, longint unsigned len);
    longint unsigned q;
    q = ((d < 0 ? -d : d) << 8) / len;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'h7fffff;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic step_word_t predict_step(logic [23:0] hx, hy, bx, by, tx, ty,
                                              logic [MIN_DIST_WIDTH-1:0] md);
    longint dhx, dhy, dbx, dby, nhx, nhy, nbx, nby;
    longint unsigned lh, lb;
    step_word_t w;
    dhx = longint'($signed(tx)) - longint'($signed(hx));
    dhy = longint'($signed(ty)) - longint'($signed(hy));
    dbx = longint'($signed(tx)) - longint'($signed(bx));
    dby = longint'($signed(ty)) - longint'($signed(by));
    lh = isqrt(dhx * dhx + dhy * dhy);
    lb = isqrt(dbx * dbx + dby * dby);
    nhx = $signed(hx); nhy = $signed(hy); nbx = $signed(bx); nby = $signed(by);
    w.moved = (lh > md) && (lb > md);
    if (w.moved) begin
      nhx += step_part(dhx, lh);
      nhy += step_part(dhy, lh);
      nbx += step_part(dbx, lb);
      nby += step_part(dby, lb);
    end
    w.hx = clamp24(nhx); w.hy = clamp24(nhy);
    w.bx = clamp24(nbx); w.by = clamp24(nby);
    return w;
  endfunction

  assign pending = expected_steps.size();

  initial errors = 0;

  always @(posedge clk) begin
    step_word_t e;
    step_word_t a;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_steps.push_back(predict_step(in_hx, in_hy, in_bx, in_by, in_tx,
                                              in_ty, min_dist));
      if (out_valid && out_ready) begin
        a = '{out_hx, out_hy, out_bx, out_by, out_moved};
        if (expected_steps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", a);
        end else begin
          e = expected_steps.pop_front();
          if (a !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp hx %h hy %h bx %h by %h m %b, got hx %h hy %h bx %h by %h m %b",
                       e.hx, e.hy, e.bx, e.by, e.moved, a.hx, a.hy, a.bx, a.by, a.moved);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for unit_step_toward_target: drives entity words and APB writes,
// stalls the result side, and gives the verdict. Uses utt_pkg and utt_checker.
module tb_top;
  import utt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 24 + 8 + 7;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic pready;
  logic [MIN_DIST_WIDTH-1:0] min_dist = MIN_DIST_RESET;
  logic calm = 1'b0;
  int errors, pending, idle_cycles;

  utt_in_if  in_ch();
  utt_out_if out_ch();

  always #10 clk = ~clk;

  unit_step_toward_target u_dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch.sink), .out_item(out_ch.source),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite), .cfg_paddr(paddr),
    .cfg_pwdata(pwdata), .cfg_prdata(prdata), .cfg_pready(pready)
  );

  utt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_hx(in_ch.head_x), .in_hy(in_ch.head_y), .in_bx(in_ch.body_x),
    .in_by(in_ch.body_y), .in_tx(in_ch.dest_x), .in_ty(in_ch.dest_y),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_hx(out_ch.new_head_x), .out_hy(out_ch.new_head_y),
    .out_bx(out_ch.new_body_x), .out_by(out_ch.new_body_y), .out_moved(out_ch.moved),
    .min_dist(min_dist), .errors(errors), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.head_x, in_ch.head_y, in_ch.body_x, in_ch.body_y,
     in_ch.dest_x, in_ch.dest_y} = '0;
    out_ch.ready = 1'b0;
  end

  // Result side stalls in about 16 percent of cycles, except in calm stretches.
  always @(negedge clk)
    out_ch.ready <= calm || ($urandom_range(99) >= 16);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_min_distance(logic [MIN_DIST_WIDTH-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CFG_ADDR_WIDTH'(REG_MIN_DISTANCE) << 2;
    pwdata <= CFG_DATA_WIDTH'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    min_dist <= v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Called at a falling edge; valid stays high into the next word unless an
  // idle cycle is drawn, so consecutive words go back to back.
  task automatic send_entity(logic [23:0] hx, hy, bx, by, tx, ty);
    while (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.head_x <= hx; in_ch.head_y <= hy; in_ch.body_x <= bx;
    in_ch.body_y <= by; in_ch.dest_x <= tx; in_ch.dest_y <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Coordinates clustered near a destination so both outcomes of the threshold occur.
  function automatic logic [23:0] near(logic [23:0] c, int span);
    return c + 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  localparam logic [23:0] MAXC = 24'h7fffff, MINC = 24'h800000;

  initial begin
    logic [23:0] t[2];
    int span;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero length, threshold edges, saturation.
    send_entity(0, 0, 0, 0, 0, 0);
    send_entity(0, 0, 24'd128, 0, 24'd128, 0);
    send_entity(0, 0, 0, 24'd129, 24'd0, 24'd258);
    send_entity(MAXC, MAXC, MINC, MINC, MAXC, MINC);
    send_entity(MINC, MINC, MAXC, MAXC, MAXC, MAXC);
    send_entity(MINC, MAXC, MAXC, MINC, MINC, MINC);
    send_entity(MAXC, 0, MINC, 0, MINC, MAXC);
    send_entity(24'h7fff80, 24'h7fff80, 0, 0, MAXC, MAXC);
    send_entity(24'h800050, 24'h800050, 0, 0, MINC, MINC);
    send_entity(24'hffff00, 24'h000100, 24'h001000, 24'hfff000, 24'h000300, 24'hfffd00);
    send_entity(24'h123456, 24'hfedcba, 24'h555555, 24'haaaaaa, 24'h0f0f0f, 24'hf0f0f0);
    drain();
    write_min_distance('0);
    send_entity(0, 0, 24'd1, 0, 24'd1, 24'd1);
    send_entity(0, 0, 0, 0, 24'd1, 0);
    drain();
    write_min_distance(23'h7fffff);
    send_entity(MINC, MINC, MINC, MINC, MAXC, MAXC);
    send_entity(0, 0, 0, 0, MAXC, 0);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: write_min_distance(MIN_DIST_RESET);
        1: write_min_distance(23'd0);
        2: write_min_distance(23'($urandom_range(4095)));
        3: write_min_distance(23'h7fffff);
        default: write_min_distance(23'($urandom_range(23'h7fffff)));
      endcase
      calm = (phase == 2);
      for (int n = 0; n < 310; n++) begin
        t[0] = 24'($urandom); t[1] = 24'($urandom);
        span = ($urandom_range(3) == 0) ? 24'h7fffff :
               ($urandom_range(1) ? 1024 : 1 << $urandom_range(22));
        send_entity(near(t[0], span), near(t[1], span), near(t[0], span),
                    near(t[1], span), t[0], t[1]);
      end
    end
    calm = 1'b0;
    drain();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
